/* hdl/gsm7u_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and character tables for the GSM 7-bit septet unpacker.
// Used by every module of the block; depends on nothing.
package gsm7u_pkg;

  // Configuration register indexes
  localparam logic CfgFillBits    = 1'b0;
  localparam logic CfgSeptetTotal = 1'b1;

  // Queue depths
  localparam int unsigned SeptetQueueDepth = 2;
  localparam int unsigned ResultQueueDepth = 2;

  // Escape septet of the default alphabet
  localparam logic [6:0] EscCode = 7'h1B;

  // One septet on its way from the unpacker to the character mapper
  typedef struct packed {
    logic [6:0] septet;
    logic       clr_esc;   // first septet of a new message
    logic       msg_end;
    logic       last;
  } septet_t;

  // One decoded character as delivered on the result side
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [1:0] len;
    logic       msg_end;
    logic       last;
  } char_t;

  // Code points of default-alphabet septets 0x00 to 0x1F
  localparam logic [15:0] LowCodes [32] = '{
    16'h0040, 16'h00A3, 16'h0024, 16'h00A5, 16'h00E8, 16'h00E9, 16'h00F9, 16'h00EC,
    16'h00F2, 16'h00C7, 16'h000A, 16'h00D8, 16'h00F8, 16'h000D, 16'h00C5, 16'h00E5,
    16'h0394, 16'h005F, 16'h03A6, 16'h0393, 16'h039B, 16'h03A9, 16'h03A0, 16'h03A8,
    16'h03A3, 16'h0398, 16'h039E, 16'h0000, 16'h00C6, 16'h00E6, 16'h00DF, 16'h00C9
  };

  // Default alphabet lookup
  function automatic logic [15:0] default_point(logic [6:0] c);
    logic [15:0] cp;
    if (c < 7'd32) begin
      cp = LowCodes[c[4:0]];
    end else begin
      case (c)
        7'h24:   cp = 16'h00A4;
        7'h40:   cp = 16'h00A1;
        7'h5B:   cp = 16'h00C4;
        7'h5C:   cp = 16'h00D6;
        7'h5D:   cp = 16'h00D1;
        7'h5E:   cp = 16'h00DC;
        7'h5F:   cp = 16'h00A7;
        7'h60:   cp = 16'h00BF;
        7'h7B:   cp = 16'h00E4;
        7'h7C:   cp = 16'h00F6;
        7'h7D:   cp = 16'h00F1;
        7'h7E:   cp = 16'h00FC;
        7'h7F:   cp = 16'h00E0;
        default: cp = {9'd0, c};
      endcase
    end
    return cp;
  endfunction

  // Extension table lookup; unknown codes map to nothing
  function automatic logic [15:0] extension_point(logic [6:0] c);
    logic [15:0] cp;
    case (c)
      7'h14:   cp = 16'h005E;
      7'h28:   cp = 16'h007B;
      7'h29:   cp = 16'h007D;
      7'h2F:   cp = 16'h005C;
      7'h3C:   cp = 16'h005B;
      7'h3D:   cp = 16'h007E;
      7'h3E:   cp = 16'h005D;
      7'h40:   cp = 16'h007C;
      7'h65:   cp = 16'h20AC;
      default: cp = 16'h0000;
    endcase
    return cp;
  endfunction

  // UTF-8 form of a code point; unused bytes are zero
  function automatic char_t utf8_encode(logic [15:0] cp);
    char_t r;
    r = '0;
    if (cp == 16'h0000) begin
      r.len = 2'd0;
    end else if (cp < 16'h0080) begin
      r.byte0 = {1'b0, cp[6:0]};
      r.len   = 2'd1;
    end else if (cp < 16'h0800) begin
      r.byte0 = {3'b110, cp[10:6]};
      r.byte1 = {2'b10, cp[5:0]};
      r.len   = 2'd2;
    end else begin
      r.byte0 = {4'b1110, cp[15:12]};
      r.byte1 = {2'b10, cp[11:6]};
      r.byte2 = {2'b10, cp[5:0]};
      r.len   = 2'd3;
    end
    return r;
  endfunction

  // Bit position of the first septet for a given fill count
  function automatic logic [2:0] start_shift(logic [2:0] fill);
    logic [2:0] s;
    if (fill == 3'd0) begin
      s = 3'd0;
    end else begin
      s = 3'd7 - fill;
    end
    return s;
  endfunction

endpackage

/* hdl/gsm7u_fifo.sv */
`timescale 1ns / 1ps
// Small register-based first-in first-out queue of generic width and depth.
// Depends on gsm7u_pkg for the default depth.
module gsm7u_fifo import gsm7u_pkg::*; #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = SeptetQueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store written entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");

endmodule

/* hdl/gsm7u_front.sv */
`timescale 1ns / 1ps
// Front end: configuration registers, octet intake and septet extraction.
// Depends on gsm7u_pkg; feeds the septet queue.
module gsm7u_front import gsm7u_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       push_i,
  input  logic [7:0] octet_i,
  input  logic       first_i,
  output logic       full_o,
  output logic       q_push_o,
  output septet_t    q_data_o,
  input  logic       q_full_i
);

  logic [2:0] fill_q;
  logic [7:0] total_q;
  logic [6:0] carry_q, carry_d;
  logic [2:0] shift_q, shift_d;
  logic [7:0] done_q, done_d;
  logic       nm_q, nm_d;
  logic       sec_vld_q, sec_vld_d;
  septet_t    sec_q, sec_d;

  logic        accept;
  logic [6:0]  carry_s;
  logic [2:0]  shift_s;
  logic [7:0]  done_s, done1, done2;
  logic        nm_s, drop, active, wrap, e1_emit, e2_emit;
  logic [3:0]  j1;
  logic [13:0] wide;
  septet_t     e1, e2;

  assign full_o = sec_vld_q || q_full_i;
  assign accept = push_i && !full_o;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      total_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFillBits:    fill_q  <= cfg_data_i[2:0];
        CfgSeptetTotal: total_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Cut the octet into at most two septets
  always_comb begin
    carry_s = first_i ? 7'd0 : carry_q;
    done_s  = first_i ? 8'd0 : done_q;
    shift_s = first_i ? start_shift(fill_q) : shift_q;
    nm_s    = first_i ? 1'b1 : nm_q;
    drop    = first_i && (fill_q != 3'd0);
    active  = (done_s < total_q);

    wide    = {6'd0, octet_i} << shift_s;
    j1      = {1'b0, shift_s} + 4'd1;
    wrap    = (j1 == 4'd7);

    e1_emit = active && !drop;
    done1   = done_s + {7'd0, e1_emit};
    e2_emit = active && wrap && (done1 < total_q);
    done2   = done1 + {7'd0, e2_emit};

    e1.septet  = wide[6:0] | carry_s;
    e1.clr_esc = nm_s;
    e1.msg_end = (done1 == total_q);
    e1.last    = !e2_emit;

    e2.septet  = wide[13:7];
    e2.clr_esc = nm_s && !e1_emit;
    e2.msg_end = (done2 == total_q);
    e2.last    = 1'b1;
  end

  // Next state and queue writes
  always_comb begin
    carry_d   = carry_q;
    shift_d   = shift_q;
    done_d    = done_q;
    nm_d      = nm_q;
    sec_vld_d = sec_vld_q;
    sec_d     = sec_q;
    q_push_o  = 1'b0;
    q_data_o  = sec_q;

    if (sec_vld_q) begin
      // drain the held second septet
      if (!q_full_i) begin
        q_push_o  = 1'b1;
        sec_vld_d = 1'b0;
      end
    end else if (accept) begin
      carry_d = carry_s;
      shift_d = shift_s;
      done_d  = done_s;
      nm_d    = nm_s;
      if (active) begin
        carry_d = wrap ? 7'd0 : wide[13:7];
        shift_d = wrap ? 3'd0 : j1[2:0];
        done_d  = done2;
        nm_d    = nm_s && !(e1_emit || e2_emit);
        if (e1_emit) begin
          q_push_o = 1'b1;
          q_data_o = e1;
          if (e2_emit) begin
            sec_vld_d = 1'b1;
            sec_d     = e2;
          end
        end else if (e2_emit) begin
          q_push_o = 1'b1;
          q_data_o = e2;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q   <= '0;
      shift_q   <= '0;
      done_q    <= '0;
      nm_q      <= 1'b0;
      sec_vld_q <= 1'b0;
    end else begin
      carry_q   <= carry_d;
      shift_q   <= shift_d;
      done_q    <= done_d;
      nm_q      <= nm_d;
      sec_vld_q <= sec_vld_d;
    end
  end

  // Hold the second septet
  always_ff @(posedge clk_i) begin
    sec_q <= sec_d;
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> !q_full_i)
    else $error("septet written into a full queue");

  a_sec_no_new_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_vld_q |-> !nm_q)
    else $error("second septet held while message start still pending");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_q != 3'd7)
    else $error("shift position out of range");

endmodule

/* hdl/gsm7u_back.sv */
`timescale 1ns / 1ps
// Back end: escape tracking and septet to UTF-8 character mapping.
// Depends on gsm7u_pkg; reads the septet queue, writes the result queue.
module gsm7u_back import gsm7u_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    sq_empty_i,
  input  septet_t sq_data_i,
  output logic    sq_pop_o,
  input  logic    rq_full_i,
  output logic    rq_push_o,
  output char_t   rq_data_o
);

  logic        esc_q, esc_d;
  logic        esc_eff;
  logic [15:0] cp;

  assign sq_pop_o  = !sq_empty_i && !rq_full_i;
  assign rq_push_o = sq_pop_o;

  // Pick the table and encode
  always_comb begin
    esc_eff = sq_data_i.clr_esc ? 1'b0 : esc_q;
    esc_d   = esc_q;
    if (esc_eff) begin
      cp    = extension_point(sq_data_i.septet);
      esc_d = 1'b0;
    end else if (sq_data_i.septet == EscCode) begin
      cp    = 16'h0000;
      esc_d = 1'b1;
    end else begin
      cp    = default_point(sq_data_i.septet);
      esc_d = 1'b0;
    end
    rq_data_o         = utf8_encode(cp);
    rq_data_o.msg_end = sq_data_i.msg_end;
    rq_data_o.last    = sq_data_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
    end else if (sq_pop_o) begin
      esc_q <= esc_d;
    end
  end

endmodule

/* hdl/gsm7_septet_unpacker_core.sv */
`timescale 1ns / 1ps
// Top level of the GSM 7-bit septet unpacker.
// Depends on gsm7u_pkg, gsm7u_front, gsm7u_back and gsm7u_fifo.

// Packed user-data octets enter through a queue-style port (push/full) and decoded
// characters leave through another (empty/pop), one septet per result, each with
// up to three UTF-8 bytes. The front end takes one octet per cycle while full is
// low and writes one septet per cycle into a short septet queue while it has room;
// an octet that yields two septets holds the second in the front end, with full
// high, until the septet queue has room. The back end maps one septet per cycle
// into a result queue while it has room, which sets the sustained output rate of
// one result per cycle. Septets are registered in the septet queue and results in
// the result queue. The user must write configuration (fill bits, septet total)
// through cfg_we_i/cfg_idx_i/cfg_data_i while the block is idle; not enforced.
module gsm7_septet_unpacker_core import gsm7u_pkg::*; #(
  parameter int unsigned SqDepth = SeptetQueueDepth,
  parameter int unsigned RqDepth = ResultQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] octet_i,
  input  logic       first_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] char_byte0_o,
  output logic [7:0] char_byte1_o,
  output logic [7:0] char_byte2_o,
  output logic [1:0] char_len_o,
  output logic       message_end_o,
  output logic       last_o
);

  logic    sq_push, sq_full, sq_pop, sq_empty;
  septet_t sq_wdata, sq_rdata;
  logic    rq_push, rq_full;
  char_t   rq_wdata, rq_rdata;

  gsm7u_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .octet_i    (octet_i),
    .first_i    (first_i),
    .full_o     (full),
    .q_push_o   (sq_push),
    .q_data_o   (sq_wdata),
    .q_full_i   (sq_full)
  );

  gsm7u_fifo #(
    .Width ($bits(septet_t)),
    .Depth (SqDepth)
  ) u_septet_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (sq_push),
    .data_i  (sq_wdata),
    .full_o  (sq_full),
    .pop_i   (sq_pop),
    .data_o  (sq_rdata),
    .empty_o (sq_empty)
  );

  gsm7u_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sq_empty_i (sq_empty),
    .sq_data_i  (sq_rdata),
    .sq_pop_o   (sq_pop),
    .rq_full_i  (rq_full),
    .rq_push_o  (rq_push),
    .rq_data_o  (rq_wdata)
  );

  gsm7u_fifo #(
    .Width ($bits(char_t)),
    .Depth (RqDepth)
  ) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .data_i  (rq_wdata),
    .full_o  (rq_full),
    .pop_i   (pop),
    .data_o  (rq_rdata),
    .empty_o (empty)
  );

  assign char_byte0_o  = rq_rdata.byte0;
  assign char_byte1_o  = rq_rdata.byte1;
  assign char_byte2_o  = rq_rdata.byte2;
  assign char_len_o    = rq_rdata.len;
  assign message_end_o = rq_rdata.msg_end;
  assign last_o        = rq_rdata.last;

endmodule

/* tb/tb_gsm7_septet_unpacker_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for gsm7_septet_unpacker_core: packs septet messages into octets,
// predicts the decoded UTF-8 characters and checks every popped transaction against them.
// Depends on gsm7u_pkg and the gsm7_septet_unpacker_core hierarchy.
module tb_gsm7_septet_unpacker_core;
  import gsm7u_pkg::*;

  localparam int unsigned HalfPeriod  = 4;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandPhases  = 36;
  localparam int unsigned CalmPhases  = 6;
  localparam int unsigned PhaseOctets = 20;
  localparam int unsigned ReportMax   = 10;

  typedef struct packed {
    logic [7:0] octet;
    logic       first;
  } octet_item_t;

  // Code points of basic septets 0x00 to 0x1F
  localparam logic [15:0] BasicLow [32] = '{
    16'h0040, 16'h00A3, 16'h0024, 16'h00A5, 16'h00E8, 16'h00E9, 16'h00F9, 16'h00EC,
    16'h00F2, 16'h00C7, 16'h000A, 16'h00D8, 16'h00F8, 16'h000D, 16'h00C5, 16'h00E5,
    16'h0394, 16'h005F, 16'h03A6, 16'h0393, 16'h039B, 16'h03A9, 16'h03A0, 16'h03A8,
    16'h03A3, 16'h0398, 16'h039E, 16'h0000, 16'h00C6, 16'h00E6, 16'h00DF, 16'h00C9
  };

  // Codes that the extension table knows, plus line feed which it does not
  localparam logic [6:0] ExtCodes [10] = '{
    7'h14, 7'h28, 7'h29, 7'h2F, 7'h3C, 7'h3D, 7'h3E, 7'h40, 7'h65, 7'h0A
  };

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       cfg_we_i   = 1'b0;
  logic       cfg_idx_i  = CfgFillBits;
  logic [7:0] cfg_data_i = 8'h00;
  logic       push       = 1'b0;
  logic [7:0] octet_i    = 8'h00;
  logic       first_i    = 1'b0;
  logic       pop        = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] char_byte0_o;
  logic [7:0] char_byte1_o;
  logic [7:0] char_byte2_o;
  logic [1:0] char_len_o;
  logic       message_end_o;
  logic       last_o;

  gsm7_septet_unpacker_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .octet_i      (octet_i),
    .first_i      (first_i),
    .empty        (empty),
    .pop          (pop),
    .char_byte0_o (char_byte0_o),
    .char_byte1_o (char_byte1_o),
    .char_byte2_o (char_byte2_o),
    .char_len_o   (char_len_o),
    .message_end_o(message_end_o),
    .last_o       (last_o)
  );

  // Free-running clock
  always #(HalfPeriod) clk_i = ~clk_i;

  octet_item_t octets_to_send [$];
  char_t       expected_chars [$];
  logic [6:0]  msg_septets [$];

  // Mirror of the configuration and of the unpack state
  logic [2:0] fill_cfg     = 3'd0;
  logic [7:0] total_cfg    = 8'd0;
  logic [6:0] carry_bits   = 7'd0;
  logic [2:0] shift_pos    = 3'd0;
  logic [7:0] septets_done = 8'd0;
  bit         esc_pending  = 1'b0;

  int unsigned mismatches      = 0;
  int unsigned cycles          = 0;
  int unsigned phase_octets    = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_served    = 0;
  bit          calm            = 1'b0;

  // Default alphabet code point
  function automatic logic [15:0] basic_point(logic [6:0] c);
    logic [15:0] cp;
    if (c < 7'd32) begin
      cp = BasicLow[c[4:0]];
    end else begin
      case (c)
        7'h24:   cp = 16'h00A4;
        7'h40:   cp = 16'h00A1;
        7'h5B:   cp = 16'h00C4;
        7'h5C:   cp = 16'h00D6;
        7'h5D:   cp = 16'h00D1;
        7'h5E:   cp = 16'h00DC;
        7'h5F:   cp = 16'h00A7;
        7'h60:   cp = 16'h00BF;
        7'h7B:   cp = 16'h00E4;
        7'h7C:   cp = 16'h00F6;
        7'h7D:   cp = 16'h00F1;
        7'h7E:   cp = 16'h00FC;
        7'h7F:   cp = 16'h00E0;
        default: cp = {9'd0, c};
      endcase
    end
    return cp;
  endfunction

  // Extension table code point; zero for codes it does not define
  function automatic logic [15:0] ext_point(logic [6:0] c);
    logic [15:0] cp;
    case (c)
      7'h14:   cp = 16'h005E;
      7'h28:   cp = 16'h007B;
      7'h29:   cp = 16'h007D;
      7'h2F:   cp = 16'h005C;
      7'h3C:   cp = 16'h005B;
      7'h3D:   cp = 16'h007E;
      7'h3E:   cp = 16'h005D;
      7'h40:   cp = 16'h007C;
      7'h65:   cp = 16'h20AC;
      default: cp = 16'h0000;
    endcase
    return cp;
  endfunction

  // Split a code point into UTF-8 bytes, unused bytes zero
  function automatic char_t to_utf8(logic [15:0] cp);
    char_t r;
    r = '0;
    if (cp == 16'h0000) begin
      r.len = 2'd0;
    end else if (cp < 16'h0080) begin
      r.byte0 = cp[7:0];
      r.len   = 2'd1;
    end else if (cp < 16'h0800) begin
      r.byte0 = 8'hC0 | 8'(cp >> 6);
      r.byte1 = 8'h80 | {2'b00, cp[5:0]};
      r.len   = 2'd2;
    end else begin
      r.byte0 = 8'hE0 | {4'h0, cp[15:12]};
      r.byte1 = 8'h80 | {2'b00, cp[11:6]};
      r.byte2 = 8'h80 | {2'b00, cp[5:0]};
      r.len   = 2'd3;
    end
    return r;
  endfunction

  // Map one septet to its character and advance the escape and count state
  function automatic char_t map_septet(logic [6:0] s);
    logic [15:0] cp;
    char_t       r;
    cp = 16'h0000;
    if (esc_pending) begin
      cp = ext_point(s);
      esc_pending = 1'b0;
    end else if (s == EscCode) begin
      esc_pending = 1'b1;
    end else begin
      cp = basic_point(s);
    end
    r = to_utf8(cp);
    septets_done = septets_done + 8'd1;
    r.msg_end = (septets_done == total_cfg);
    r.last = 1'b0;
    return r;
  endfunction

  // Work out the characters that one accepted octet gives
  task automatic decode_octet(input logic [7:0] oct, input logic first);
    char_t       res [2];
    int          n;
    int unsigned j;
    int unsigned wide;
    logic [6:0]  sep;
    bit          drop;
    n = 0;
    drop = 1'b0;
    if (first) begin
      carry_bits   = 7'd0;
      septets_done = 8'd0;
      esc_pending  = 1'b0;
      shift_pos    = 3'((7 - int'(fill_cfg)) % 7);
      drop         = (fill_cfg != 3'd0);
    end
    // Total already reached: nothing out, state held
    if (septets_done >= total_cfg) return;
    j    = shift_pos % 7;
    wide = {24'd0, oct};
    sep  = 7'(((wide << j) & 32'h7F) | {25'd0, carry_bits});
    carry_bits = 7'((wide >> (7 - j)) & 32'h7F);
    if (!drop) begin
      res[n] = map_septet(sep);
      n++;
    end
    j++;
    // Whole septet left in the carry
    if (j == 7) begin
      if (septets_done < total_cfg) begin
        res[n] = map_septet(carry_bits);
        n++;
      end
      carry_bits = 7'd0;
      j = 0;
    end
    shift_pos = 3'(j);
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) res[i].last = 1'b1;
      expected_chars.push_back(res[i]);
    end
  endtask

  task automatic queue_octet(input logic [7:0] oct, input logic first);
    octet_item_t it;
    it.octet = oct;
    it.first = first;
    octets_to_send.push_back(it);
    phase_octets++;
  endtask

  // Pack msg_septets behind the fill bits, least significant bit first
  task automatic queue_message(input logic [2:0] fill);
    bit         stream [$];
    logic [7:0] oct;
    int         b;
    for (b = 0; b < int'(fill); b++) stream.push_back(1'($urandom_range(0, 1)));
    foreach (msg_septets[i]) begin
      for (b = 0; b < 7; b++) stream.push_back(msg_septets[i][b]);
    end
    if (stream.size() == 0) stream.push_back(1'($urandom_range(0, 1)));
    while (stream.size() % 8 != 0) stream.push_back(1'($urandom_range(0, 1)));
    for (int k = 0; k < stream.size() / 8; k++) begin
      for (b = 0; b < 8; b++) oct[b] = stream[k * 8 + b];
      queue_octet(oct, k == 0);
    end
  endtask

  // Septet mix weighted towards escapes and table edges
  function automatic logic [6:0] random_septet();
    logic [6:0] s;
    case ($urandom_range(0, 9))
      0, 1:    s = EscCode;
      2:       s = ExtCodes[$urandom_range(0, 9)];
      3:       s = $urandom_range(0, 1) ? 7'h7F : 7'h00;
      default: s = 7'($urandom_range(0, 127));
    endcase
    return s;
  endfunction

  // Wait until the block has nothing left to do
  task automatic drain();
    while (octets_to_send.size() != 0 || expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write both registers while idle, upper data bits of the fill count as noise
  task automatic configure(input logic [2:0] fill, input logic [7:0] total);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgFillBits;
    cfg_data_i <= {5'($urandom_range(0, 31)), fill};
    fill_cfg = fill;
    @(negedge clk_i);
    cfg_idx_i  <= CfgSeptetTotal;
    cfg_data_i <= total;
    total_cfg = total;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    phase_octets = 0;
  endtask

  // Sender: record accepted transactions and predict their results
  bit taken = 1'b0;
  always @(posedge clk_i) begin
    if (push && !full) begin
      decode_octet(octet_i, first_i);
      void'(octets_to_send.pop_front());
      taken = 1'b1;
    end
  end

  // Sender: offer the next octet, with short idle bursts
  int unsigned send_gap = 0;
  always @(negedge clk_i) begin
    bit          may_gap;
    logic        push_nxt;
    octet_item_t it;
    may_gap  = !push || taken;
    taken    = 1'b0;
    push_nxt = 1'b0;
    it.octet = 8'($urandom);
    it.first = 1'($urandom_range(0, 1));
    if (send_gap > 0) begin
      send_gap--;
    end else if (octets_to_send.size() != 0) begin
      if (may_gap && !calm && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 2);
      end else begin
        push_nxt = 1'b1;
        it = octets_to_send[0];
      end
    end
    push    <= push_nxt;
    octet_i <= it.octet;
    first_i <= it.first;
  end

  // Receiver: pop with idle bursts and the occasional long hold-off
  int unsigned pop_gap   = 0;
  int unsigned hold_left = 0;
  always @(negedge clk_i) begin
    logic pop_nxt;
    pop_nxt = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) holds_served++;
    end else if (holds_served < holds_requested) begin
      hold_left = LongHold;
    end else if (pop_gap > 0) begin
      pop_gap--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      pop_gap = $urandom_range(0, 2);
    end else begin
      pop_nxt = 1'b1;
    end
    pop <= pop_nxt;
  end

  // Monitor: compare each popped transaction with the oldest expectation
  always @(posedge clk_i) begin
    char_t exp_c;
    if (pop && !empty) begin
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax) begin
          $display("unexpected character: bytes %h %h %h len %0d end %b last %b",
                   char_byte0_o, char_byte1_o, char_byte2_o, char_len_o,
                   message_end_o, last_o);
        end
      end else begin
        exp_c = expected_chars.pop_front();
        if (char_byte0_o !== exp_c.byte0 || char_byte1_o !== exp_c.byte1 ||
            char_byte2_o !== exp_c.byte2 || char_len_o !== exp_c.len ||
            message_end_o !== exp_c.msg_end || last_o !== exp_c.last) begin
          mismatches++;
          if (mismatches <= ReportMax) begin
            $display("mismatch: expected %h %h %h len %0d end %b last %b", exp_c.byte0,
                     exp_c.byte1, exp_c.byte2, exp_c.len, exp_c.msg_end, exp_c.last);
            $display("          actual   %h %h %h len %0d end %b last %b", char_byte0_o,
                     char_byte1_o, char_byte2_o, char_len_o, message_end_o, last_o);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus phases
  initial begin
    logic [2:0]  fill;
    logic [7:0]  total;
    int unsigned n;
    int unsigned kind;

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Total of zero after reset: octets give nothing
    queue_octet(8'hFF, 1'b0);
    queue_octet(8'h00, 1'b0);
    drain();

    // No start flag yet: decode from the zero state, fill count unused
    configure(3'd3, 8'd10);
    queue_octet(8'hFF, 1'b0);
    queue_octet(8'h80, 1'b0);
    queue_octet(8'h01, 1'b0);
    drain();

    // Escapes: euro, bracket, double escape, escape then line feed, unknown code
    configure(3'd0, 8'd255);
    msg_septets = '{7'h1B, 7'h65, 7'h1B, 7'h3C, 7'h1B, 7'h1B, 7'h1B, 7'h0A,
                    7'h1B, 7'h00, 7'h00, 7'h7F, 7'h24, 7'h10};
    queue_message(3'd0);
    drain();

    // Seven fill bits; total reached, so the trailing octet gives nothing
    configure(3'd7, 8'd2);
    msg_septets = '{7'h7F, 7'h40};
    queue_message(3'd7);
    queue_octet(8'hFF, 1'b0);
    drain();

    // Six fill bits, single septet
    configure(3'd6, 8'd1);
    msg_septets = '{7'h41};
    queue_message(3'd6);
    drain();

    // Random phases: mostly well-formed messages, some noise and broken ones
    for (int unsigned phase = 0; phase < RandPhases; phase++) begin
      fill = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0:       total = 8'd0;
        1:       total = 8'd255;
        2:       total = 8'($urandom_range(20, 60));
        default: total = 8'($urandom_range(1, 12));
      endcase
      // Hold-off phases need results to back up the block
      if ((phase == 5 || phase == 20) && total == 8'd0) total = 8'd12;
      configure(fill, total);
      if (phase == 5 || phase == 20) holds_requested++;
      if (phase >= RandPhases - CalmPhases) calm = 1'b1;
      while (phase_octets < PhaseOctets) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          repeat ($urandom_range(1, 4)) queue_octet(8'($urandom), 1'($urandom_range(0, 1)));
        end else begin
          if (total == 8'd0) n = $urandom_range(1, 6);
          else if (total > 8'd60) n = $urandom_range(5, 30);
          else n = total;
          if (kind == 1) n = $urandom_range(0, n - 1);
          if (kind == 2) n = n + $urandom_range(1, 3);
          msg_septets.delete();
          repeat (n) msg_septets.push_back(random_septet());
          queue_message(fill);
          // Continuation octets past the end of the message
          if (kind == 3) begin
            repeat ($urandom_range(1, 2)) queue_octet(8'($urandom), 1'b0);
          end
        end
      end
      drain();
    end

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
